// ----- rtl/hsiu_pkg.sv -----
// Package for the halfword stack instruction unit.
// Request/response payload types, command codes and halfword constants.
// No dependencies.
package hsiu_pkg;

    localparam int HALF_W = 18;
    localparam int WORD_W = 36;

    localparam logic [WORD_W-1:0] ONE_ONE        = 36'o000001000001;
    localparam logic [WORD_W-1:0] FLAG_MASK_INIT = 36'o777777000000;
    localparam logic [HALF_W-1:0] HALF_ONES      = 18'o777777;

    typedef enum logic [1:0] {
        CMD_PUSHJ = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_POPJ  = 2'd3
    } hsiu_cmd_t;

    typedef struct packed {
        hsiu_cmd_t          cmd;
        logic [WORD_W-1:0]  ac_word;
        logic [WORD_W-1:0]  mem_word;
        logic [HALF_W-1:0]  pc;
        logic [HALF_W-1:0]  effective_address;
        logic [WORD_W-1:0]  status_word;
    } hsiu_req_t;

    typedef struct packed {
        logic [WORD_W-1:0]  new_ac_word;
        logic               mem_write_en;
        logic [HALF_W-1:0]  mem_write_addr;
        logic [WORD_W-1:0]  mem_write_data;
        logic               jump_taken;
        logic [HALF_W-1:0]  new_pc;
        logic               set_trap2;
        logic               clear_bis;
        logic               exit_kind;
    } hsiu_rsp_t;

endpackage

// ----- rtl/hsiu_exec.sv -----
// Execute logic for PUSHJ, PUSH, POP and POPJ on one registered request.
// Purely combinational; depends on hsiu_pkg.
module hsiu_exec (
    input  hsiu_pkg::hsiu_req_t       req,
    input  logic [hsiu_pkg::WORD_W-1:0] flag_mask,
    output hsiu_pkg::hsiu_rsp_t       rsp
);
    import hsiu_pkg::*;

    logic [WORD_W-1:0] push_ac;
    logic [WORD_W-1:0] pop_ac;
    logic              push_ovf;
    logic              pop_ovf;

    // 1,,1 added or removed with the carry crossing halves
    assign push_ac  = req.ac_word + ONE_ONE;
    assign pop_ac   = req.ac_word - ONE_ONE;
    assign push_ovf = (push_ac[WORD_W-1:HALF_W] == '0);
    assign pop_ovf  = (pop_ac[WORD_W-1:HALF_W] == HALF_ONES);

    always_comb begin
        rsp = '0;
        case (req.cmd)
            CMD_PUSHJ: begin
                rsp.new_ac_word    = push_ac;
                rsp.mem_write_en   = 1'b1;
                rsp.mem_write_addr = push_ac[HALF_W-1:0];
                rsp.mem_write_data = (req.status_word & flag_mask)
                                   | {{(WORD_W-HALF_W){1'b0}}, req.pc + HALF_W'(1)};
                rsp.clear_bis      = 1'b1;
                rsp.jump_taken     = 1'b1;
                rsp.new_pc         = req.effective_address;
                rsp.set_trap2      = push_ovf;
            end
            CMD_PUSH: begin
                rsp.new_ac_word = push_ac;
                if (push_ovf) begin
                    rsp.set_trap2 = 1'b1;
                    rsp.exit_kind = 1'b1;
                end else begin
                    rsp.mem_write_en   = 1'b1;
                    rsp.mem_write_addr = push_ac[HALF_W-1:0];
                    rsp.mem_write_data = req.mem_word;
                end
            end
            CMD_POP: begin
                rsp.new_ac_word    = pop_ac;
                rsp.mem_write_en   = 1'b1;
                rsp.mem_write_addr = req.effective_address;
                rsp.mem_write_data = req.mem_word;
                rsp.set_trap2      = pop_ovf;
                rsp.exit_kind      = pop_ovf;
            end
            CMD_POPJ: begin
                rsp.new_ac_word = pop_ac;
                if (pop_ovf) begin
                    rsp.set_trap2 = 1'b1;
                    rsp.exit_kind = 1'b1;
                end else begin
                    rsp.jump_taken = 1'b1;
                    rsp.new_pc     = req.mem_word[HALF_W-1:0];
                end
            end
            default: begin
                rsp = '0;
            end
        endcase
    end

endmodule

// ----- rtl/halfword_stack_instruction_unit_core.sv -----
// Top level of the halfword stack instruction unit.
// Input register, hsiu_exec, result register and the flag mask register.
// Depends on hsiu_pkg and hsiu_exec.
//
// Usage:
//   s_valid/s_ready/s_req carry one stack instruction request (command, pointer
//   word, memory word, PC, E, status). m_valid/m_ready/m_rsp return one result
//   per request: new pointer word, store, jump, trap and BIS controls.
//   cfg_wen/cfg_wdata write the mask of status bits that PUSHJ saves with the
//   return PC; write it only while no request is in flight.
// Timing:
//   Two register stages: a request accepted into the input register is
//   offered on m_rsp from the result register. One request per cycle is
//   sustained while m_ready stays high; the stack arithmetic is a single
//   36-bit add or subtract between the input and result registers.
// Reset:
//   aresetn low empties both stages and loads the mask with the left half.
// Stall:
//   With m_ready low the result holds; one more request fills the input
//   stage, then s_ready drops until the result is taken.
module halfword_stack_instruction_unit_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  hsiu_pkg::hsiu_req_t         s_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output hsiu_pkg::hsiu_rsp_t         m_rsp,
    input  logic                        cfg_wen,
    input  logic [hsiu_pkg::WORD_W-1:0] cfg_wdata
);
    import hsiu_pkg::*;

    logic [WORD_W-1:0] mask_reg;
    hsiu_req_t         req_reg;
    logic              req_valid_reg;
    hsiu_rsp_t         rsp_reg;
    logic              rsp_valid_reg;
    hsiu_rsp_t         rsp_next;
    logic              rsp_ready;

    assign rsp_ready = !rsp_valid_reg || m_ready;
    assign s_ready   = !req_valid_reg || rsp_ready;
    assign m_valid   = rsp_valid_reg;
    assign m_rsp     = rsp_reg;

    hsiu_exec u_exec (
        .req       (req_reg),
        .flag_mask (mask_reg),
        .rsp       (rsp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= FLAG_MASK_INIT;
        end else if (cfg_wen) begin
            mask_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg <= s_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_valid_reg <= 1'b0;
        end else if (rsp_ready) begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_ready && req_valid_reg) begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_req_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> req_valid_reg)
        else $error("accepted request not held in input stage");

    a_no_store_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rsp.mem_write_en |->
            (m_rsp.mem_write_addr == '0) && (m_rsp.mem_write_data == '0))
        else $error("store fields nonzero without store");

    a_no_jump_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rsp.jump_taken |-> (m_rsp.new_pc == '0))
        else $error("new_pc nonzero without jump");

    a_exit_trap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.exit_kind |-> m_rsp.set_trap2 && !m_rsp.clear_bis)
        else $error("early exit without overflow trap");
`endif

endmodule

// ----- verif/halfword_stack_instruction_unit_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for halfword_stack_instruction_unit_core: directed and random
// stack requests under several flag masks and handshake pacing modes.
// Depends on hsiu_pkg and the core RTL.
module halfword_stack_instruction_unit_core_tb;
    import hsiu_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    hsiu_req_t           s_req = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    hsiu_rsp_t           m_rsp;
    logic                cfg_wen = 1'b0;
    logic [WORD_W-1:0]   cfg_wdata = '0;

    hsiu_req_t           pending_req[$];
    hsiu_rsp_t           expected_rsp[$];
    logic [WORD_W-1:0]   flag_mask_now = FLAG_MASK_INIT;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  accepted_cnt = 0;
    int                  checked_cnt = 0;
    int                  trap_cnt = 0;
    int                  error_cnt = 0;
    int                  mask_settings = 1;

    halfword_stack_instruction_unit_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic hsiu_rsp_t stack_step(hsiu_req_t r, logic [WORD_W-1:0] mask);
        hsiu_rsp_t   o;
        logic [HALF_W-1:0] cnt, adr, nc, na;
        logic        carry;
        logic        ovf;
        o = '0;
        cnt = r.ac_word[WORD_W-1:HALF_W];
        adr = r.ac_word[HALF_W-1:0];
        if (r.cmd == CMD_PUSHJ || r.cmd == CMD_PUSH) begin
            {carry, na} = {1'b0, adr} + 19'd1;
            nc = cnt + 18'd1 + {17'd0, carry};
            ovf = (nc == '0);
        end else begin
            na = adr - 18'd1;
            nc = cnt - 18'd1 - {17'd0, (adr == '0)};
            ovf = (nc == HALF_ONES);
        end
        o.new_ac_word = {nc, na};
        case (r.cmd)
            CMD_PUSHJ: begin
                o.mem_write_en   = 1'b1;
                o.mem_write_addr = na;
                o.mem_write_data = (r.status_word & mask) | {18'd0, r.pc + 18'd1};
                o.clear_bis      = 1'b1;
                o.jump_taken     = 1'b1;
                o.new_pc         = r.effective_address;
                o.set_trap2      = ovf;
            end
            CMD_PUSH: begin
                if (ovf) begin
                    o.set_trap2 = 1'b1;
                    o.exit_kind = 1'b1;
                end else begin
                    o.mem_write_en   = 1'b1;
                    o.mem_write_addr = na;
                    o.mem_write_data = r.mem_word;
                end
            end
            CMD_POP: begin
                o.mem_write_en   = 1'b1;
                o.mem_write_addr = r.effective_address;
                o.mem_write_data = r.mem_word;
                o.set_trap2      = ovf;
                o.exit_kind      = ovf;
            end
            default: begin
                if (ovf) begin
                    o.set_trap2 = 1'b1;
                    o.exit_kind = 1'b1;
                end else begin
                    o.jump_taken = 1'b1;
                    o.new_pc     = r.mem_word[HALF_W-1:0];
                end
            end
        endcase
        return o;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsp.push_back(stack_step(s_req, flag_mask_now));
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_req   <= pending_req.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        hsiu_rsp_t exp_rsp;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsp.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display("%0t: result with no request outstanding: %p", $time, m_rsp);
                end else begin
                    exp_rsp = expected_rsp.pop_front();
                    checked_cnt++;
                    if (exp_rsp.set_trap2)
                        trap_cnt++;
                    if (m_rsp.new_ac_word !== exp_rsp.new_ac_word ||
                        m_rsp.mem_write_en !== exp_rsp.mem_write_en ||
                        m_rsp.mem_write_addr !== exp_rsp.mem_write_addr ||
                        m_rsp.mem_write_data !== exp_rsp.mem_write_data ||
                        m_rsp.jump_taken !== exp_rsp.jump_taken ||
                        m_rsp.new_pc !== exp_rsp.new_pc ||
                        m_rsp.set_trap2 !== exp_rsp.set_trap2 ||
                        m_rsp.clear_bis !== exp_rsp.clear_bis ||
                        m_rsp.exit_kind !== exp_rsp.exit_kind) begin
                        error_cnt++;
                        if (error_cnt <= 10) begin
                            $display("%0t: result %0d mismatch", $time, checked_cnt);
                            $display("  exp ac=%o wen=%b wa=%o wd=%o jmp=%b pc=%o trap=%b bis=%b ex=%b",
                                exp_rsp.new_ac_word, exp_rsp.mem_write_en,
                                exp_rsp.mem_write_addr, exp_rsp.mem_write_data,
                                exp_rsp.jump_taken, exp_rsp.new_pc, exp_rsp.set_trap2,
                                exp_rsp.clear_bis, exp_rsp.exit_kind);
                            $display("  got ac=%o wen=%b wa=%o wd=%o jmp=%b pc=%o trap=%b bis=%b ex=%b",
                                m_rsp.new_ac_word, m_rsp.mem_write_en,
                                m_rsp.mem_write_addr, m_rsp.mem_write_data,
                                m_rsp.jump_taken, m_rsp.new_pc, m_rsp.set_trap2,
                                m_rsp.clear_bis, m_rsp.exit_kind);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_req(hsiu_cmd_t cmd, logic [HALF_W-1:0] cnt, logic [HALF_W-1:0] adr,
                           logic [WORD_W-1:0] mem, logic [HALF_W-1:0] pc,
                           logic [HALF_W-1:0] ea, logic [WORD_W-1:0] status);
        hsiu_req_t r;
        r.cmd               = cmd;
        r.ac_word           = {cnt, adr};
        r.mem_word          = mem;
        r.pc                = pc;
        r.effective_address = ea;
        r.status_word       = status;
        pending_req.push_back(r);
    endtask

    function automatic logic [HALF_W-1:0] rand_half();
        int sel;
        sel = $urandom_range(7);
        case (sel)
            0: return '0;
            1: return 18'd1;
            2: return HALF_ONES - 18'd1;
            3: return HALF_ONES;
            default: return 18'($urandom_range(262143));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        logic [31:0] hi;
        int          sel;
        sel = $urandom_range(15);
        hi = $urandom();
        if (sel == 0)
            return '0;
        if (sel == 1)
            return {WORD_W{1'b1}};
        return {hi[3:0], $urandom()};
    endfunction

    task automatic drain();
        while (pending_req.size() > 0 || s_valid || expected_rsp.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_flag_mask(logic [WORD_W-1:0] value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        flag_mask_now = value;
        mask_settings++;
    endtask

    initial begin
        logic [WORD_W-1:0] ones;
        logic [WORD_W-1:0] phase_mask;
        int                directed_cnt;
        ones = {WORD_W{1'b1}};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        add_req(CMD_PUSHJ, 18'o0, 18'o0, '0, 18'o0, 18'o0, ones);
        add_req(CMD_PUSHJ, HALF_ONES, HALF_ONES, ones, HALF_ONES, HALF_ONES, ones);
        add_req(CMD_PUSHJ, 18'o777776, HALF_ONES, '0, 18'o123456, 18'o1, '0);
        add_req(CMD_PUSHJ, HALF_ONES, 18'o0, ones, 18'o777776, 18'o765432, 36'o525252525252);
        add_req(CMD_PUSH, 18'o0, 18'o0, ones, 18'o0, HALF_ONES, '0);
        add_req(CMD_PUSH, HALF_ONES, 18'o5, ones, 18'o1, 18'o2, ones);
        add_req(CMD_PUSH, 18'o777776, HALF_ONES, 36'o252525252525, 18'o0, 18'o0, '0);
        add_req(CMD_PUSH, 18'o1, HALF_ONES, '0, HALF_ONES, HALF_ONES, ones);
        add_req(CMD_PUSH, HALF_ONES, HALF_ONES, ones, 18'o0, 18'o0, ones);
        add_req(CMD_POP, 18'o1, 18'o1, ones, 18'o0, HALF_ONES, '0);
        add_req(CMD_POP, 18'o0, 18'o5, '0, HALF_ONES, 18'o0, ones);
        add_req(CMD_POP, 18'o1, 18'o0, 36'o525252525252, 18'o0, 18'o333333, '0);
        add_req(CMD_POP, 18'o0, 18'o0, ones, HALF_ONES, HALF_ONES, ones);
        add_req(CMD_POP, HALF_ONES, HALF_ONES, '0, 18'o0, 18'o0, '0);
        add_req(CMD_POPJ, 18'o2, 18'o0, ones, 18'o0, 18'o0, '0);
        add_req(CMD_POPJ, 18'o0, 18'o1, ones, HALF_ONES, HALF_ONES, ones);
        add_req(CMD_POPJ, 18'o1, 18'o0, 36'o123456654321, 18'o0, 18'o0, ones);
        add_req(CMD_POPJ, HALF_ONES, HALF_ONES, '0, 18'o0, HALF_ONES, '0);
        add_req(CMD_POPJ, 18'o1, 18'o1, 36'o000000777777, 18'o0, 18'o0, '0);
        add_req(CMD_POPJ, 18'o0, 18'o0, '0, 18'o0, 18'o0, ones);
        directed_cnt = pending_req.size();
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: phase_mask = '0;
                1: phase_mask = ones;
                2: phase_mask = 36'o000000777777;
                default: phase_mask = rand_word();
            endcase
            write_flag_mask(phase_mask);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int i = 0; i < 200; i++)
                add_req(hsiu_cmd_t'($urandom_range(3)), rand_half(), rand_half(),
                        rand_word(), rand_half(), rand_half(), rand_word());
            drain();
        end

        repeat (8) @(posedge aclk);
        if (expected_rsp.size() != 0)
            error_cnt++;
        $display("%0d requests (%0d directed) checked under %0d flag masks and four pacing modes",
                 accepted_cnt, directed_cnt, mask_settings);
        $display("%0d results compared, %0d with the overflow trap, %0d failures",
                 checked_cnt, trap_cnt, error_cnt);
        if (error_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #400000;
        $display("timeout with %0d results outstanding", expected_rsp.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
